FILE: src/dvps_pkg.sv
package dvps_pkg;

   // Command codes carried on req_tuser
   localparam logic [2:0] CMD_INIT           = 3'd0;
   localparam logic [2:0] CMD_DEINIT         = 3'd1;
   localparam logic [2:0] CMD_SET_VOLUME     = 3'd2;
   localparam logic [2:0] CMD_SET_POWER      = 3'd3;
   localparam logic [2:0] CMD_STREAM_STARTED = 3'd4;
   localparam logic [2:0] CMD_BUS_ERROR      = 3'd5;

   // Power states and requested power modes
   localparam logic [1:0] PWR_OFF     = 2'd0;
   localparam logic [1:0] PWR_STANDBY = 2'd1;
   localparam logic [1:0] PWR_ON      = 2'd2;

   // Configuration register indexes
   localparam logic [1:0] CSR_MAX_VOLUME  = 2'd0;
   localparam logic [1:0] CSR_PIN_PRESENT = 2'd1;

   // DAC page 0 register addresses
   localparam logic [6:0] REG_PAGE     = 7'h00;
   localparam logic [6:0] REG_RESET    = 7'h01;
   localparam logic [6:0] REG_POWER    = 7'h02;
   localparam logic [6:0] REG_MUTE     = 7'h03;
   localparam logic [6:0] REG_PLL_REF  = 7'h0D;
   localparam logic [6:0] REG_CLK_MASK = 7'h25;
   localparam logic [6:0] REG_ROUTING  = 7'h2A;
   localparam logic [6:0] REG_VOL_L    = 7'h3D;
   localparam logic [6:0] REG_VOL_R    = 7'h3E;
   localparam logic [6:0] PIN_ADDR     = 7'h00;

   // Register values
   localparam logic [7:0] VAL_ZERO      = 8'h00;
   localparam logic [7:0] VAL_MUTE_BOTH = 8'h11;
   localparam logic [7:0] VAL_STANDBY   = 8'h10;
   localparam logic [7:0] VAL_RESET_ALL = 8'h11;
   localparam logic [7:0] VAL_PLL_REF   = 8'h10;
   localparam logic [7:0] VAL_CLK_MASK  = 8'h08;
   localparam logic [7:0] VAL_ROUTING   = 8'h11;
   localparam logic [7:0] VAL_PIN_LOW   = 8'h00;
   localparam logic [7:0] VAL_PIN_HIGH  = 8'h01;

   localparam logic [4:0] DELAY_NONE   = 5'd0;
   localparam logic [4:0] DELAY_SETTLE = 5'd20;

   // Volume code constants
   localparam logic [7:0]  CODE_MUTE   = 8'hFF;
   localparam logic [8:0]  CODE_BASE   = 9'h030;
   localparam logic [8:0]  CODE_CAP    = 9'h0FE;
   localparam logic [15:0] RECIP_FIVE  = 16'd52429;  // 2^18 / 5, rounded up
   localparam int          RECIP_SHIFT = 18;

   localparam logic [3:0] STEP_MAX = 4'd13;

   typedef enum logic [1:0] {
      KIND_WRITE,
      KIND_PIN,
      KIND_VOL
   } kind_type;

   typedef enum logic [2:0] {
      SEQ_INIT,
      SEQ_SHUTDOWN,
      SEQ_VOLUME,
      SEQ_PWR_ON,
      SEQ_MUTE,
      SEQ_STREAM
   } seq_type;

   typedef struct packed {
      kind_type   kind;
      logic [6:0] addr;
      logic [7:0] value;
      logic [4:0] delay;
      logic       stop;
   } entry_type;

   typedef struct packed {
      logic      vol_store;
      logic      vol_start;
      logic      load;
      entry_type entry;
      logic      last;
   } dp_cmd_type;

   typedef struct packed {
      logic vol_done;
      logic pin_present;
   } dp_status_type;

   function automatic entry_type mk_entry(kind_type kind, logic [6:0] addr,
                                          logic [7:0] value, logic [4:0] delay,
                                          logic stop);
      entry_type e;
      e.kind  = kind;
      e.addr  = addr;
      e.value = value;
      e.delay = delay;
      e.stop  = stop;
      return e;
   endfunction

   // Script of each sequence, one entry per step
   function automatic entry_type script_entry(seq_type seq, logic [3:0] step);
      entry_type e;
      e = mk_entry(KIND_WRITE, REG_PAGE, VAL_ZERO, DELAY_NONE, 1'b1);
      unique case (seq)
         SEQ_INIT: begin
            unique case (step)
               4'd0:  e = mk_entry(KIND_PIN,   PIN_ADDR,     VAL_PIN_LOW,   DELAY_NONE,   1'b0);
               4'd1:  e = mk_entry(KIND_WRITE, REG_PAGE,     VAL_ZERO,      DELAY_NONE,   1'b0);
               4'd2:  e = mk_entry(KIND_WRITE, REG_MUTE,     VAL_MUTE_BOTH, DELAY_NONE,   1'b0);
               4'd3:  e = mk_entry(KIND_WRITE, REG_POWER,    VAL_STANDBY,   DELAY_NONE,   1'b0);
               4'd4:  e = mk_entry(KIND_WRITE, REG_RESET,    VAL_RESET_ALL, DELAY_NONE,   1'b0);
               4'd5:  e = mk_entry(KIND_WRITE, REG_PAGE,     VAL_ZERO,      DELAY_SETTLE, 1'b0);
               4'd6:  e = mk_entry(KIND_WRITE, REG_MUTE,     VAL_MUTE_BOTH, DELAY_NONE,   1'b0);
               4'd7:  e = mk_entry(KIND_WRITE, REG_POWER,    VAL_STANDBY,   DELAY_NONE,   1'b0);
               4'd8:  e = mk_entry(KIND_WRITE, REG_PLL_REF,  VAL_PLL_REF,   DELAY_NONE,   1'b0);
               4'd9:  e = mk_entry(KIND_WRITE, REG_CLK_MASK, VAL_CLK_MASK,  DELAY_NONE,   1'b0);
               4'd10: e = mk_entry(KIND_WRITE, REG_ROUTING,  VAL_ROUTING,   DELAY_NONE,   1'b0);
               4'd11: e = mk_entry(KIND_VOL,   REG_VOL_L,    VAL_ZERO,      DELAY_NONE,   1'b0);
               4'd12: e = mk_entry(KIND_VOL,   REG_VOL_R,    VAL_ZERO,      DELAY_NONE,   1'b0);
               4'd13: e = mk_entry(KIND_WRITE, REG_POWER,    VAL_ZERO,      DELAY_NONE,   1'b1);
               default: e = mk_entry(KIND_WRITE, REG_PAGE, VAL_ZERO, DELAY_NONE, 1'b1);
            endcase
         end
         SEQ_SHUTDOWN: begin
            unique case (step)
               4'd0:  e = mk_entry(KIND_PIN,   PIN_ADDR,  VAL_PIN_LOW,   DELAY_NONE, 1'b0);
               4'd1:  e = mk_entry(KIND_WRITE, REG_MUTE,  VAL_MUTE_BOTH, DELAY_NONE, 1'b0);
               4'd2:  e = mk_entry(KIND_WRITE, REG_POWER, VAL_STANDBY,   DELAY_NONE, 1'b1);
               default: e = mk_entry(KIND_WRITE, REG_PAGE, VAL_ZERO, DELAY_NONE, 1'b1);
            endcase
         end
         SEQ_VOLUME: begin
            unique case (step)
               4'd0:  e = mk_entry(KIND_VOL, REG_VOL_L, VAL_ZERO, DELAY_NONE, 1'b0);
               4'd1:  e = mk_entry(KIND_VOL, REG_VOL_R, VAL_ZERO, DELAY_NONE, 1'b1);
               default: e = mk_entry(KIND_WRITE, REG_PAGE, VAL_ZERO, DELAY_NONE, 1'b1);
            endcase
         end
         SEQ_PWR_ON: begin
            unique case (step)
               4'd0:  e = mk_entry(KIND_WRITE, REG_POWER, VAL_ZERO,     DELAY_NONE,   1'b0);
               4'd1:  e = mk_entry(KIND_VOL,   REG_VOL_L, VAL_ZERO,     DELAY_SETTLE, 1'b0);
               4'd2:  e = mk_entry(KIND_VOL,   REG_VOL_R, VAL_ZERO,     DELAY_NONE,   1'b0);
               4'd3:  e = mk_entry(KIND_WRITE, REG_MUTE,  VAL_ZERO,     DELAY_NONE,   1'b0);
               4'd4:  e = mk_entry(KIND_PIN,   PIN_ADDR,  VAL_PIN_HIGH, DELAY_NONE,   1'b1);
               default: e = mk_entry(KIND_WRITE, REG_PAGE, VAL_ZERO, DELAY_NONE, 1'b1);
            endcase
         end
         SEQ_MUTE: begin
            unique case (step)
               4'd0:  e = mk_entry(KIND_PIN,   PIN_ADDR, VAL_PIN_LOW,   DELAY_NONE, 1'b0);
               4'd1:  e = mk_entry(KIND_WRITE, REG_MUTE, VAL_MUTE_BOTH, DELAY_NONE, 1'b1);
               default: e = mk_entry(KIND_WRITE, REG_PAGE, VAL_ZERO, DELAY_NONE, 1'b1);
            endcase
         end
         SEQ_STREAM: begin
            e = mk_entry(KIND_WRITE, REG_POWER, VAL_ZERO, DELAY_NONE, 1'b1);
         end
         default: begin
            e = mk_entry(KIND_WRITE, REG_PAGE, VAL_ZERO, DELAY_NONE, 1'b1);
         end
      endcase
      return e;
   endfunction

endpackage

FILE: src/dvps_datapath.sv
module dvps_datapath import dvps_pkg::*; #(
   parameter int VOLUME_FRAC_BITS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [1:0]         csr_index,
   input  logic [6:0]         csr_wdata,
   input  logic signed [16:0] req_volume_db,
   input  dp_cmd_type         cmd,
   output dp_status_type      status,
   output logic               rsp_target,
   output logic [6:0]         rsp_reg_addr,
   output logic [7:0]         rsp_reg_value,
   output logic [4:0]         rsp_delay_before_ms,
   output logic               rsp_last
);

   localparam int F  = VOLUME_FRAC_BITS;
   localparam int XW = (F + 13 > 20) ? F + 13 : 20;
   localparam int PW = F + 12;
   localparam logic signed [XW-1:0] MUTE_LIMIT  = XW'(-30 * (1 << F));
   localparam logic signed [XW-1:0] UPPER_LIMIT = XW'(-25 * (1 << F));
   localparam logic signed [XW-1:0] ROLL_OFFSET = XW'(30 * (1 << F));
   localparam logic signed [XW-1:0] X_TOP       = XW'(1030 * (1 << F));
   localparam logic signed [XW-1:0] X_HALF      = XW'(5 * (1 << F) / 2);
   localparam logic signed [16:0]   VOL_RESET   = 17'(-15 * (1 << F));

   logic signed [6:0]    max_volume_ff, max_volume_in;
   logic                 pin_present_ff, pin_present_in;
   logic signed [16:0]   volume_level_ff, volume_level_in;
   logic [3:0]           vld_ff;

   logic signed [XW-1:0] vol_ext, max_ext, slope_term, x_upper, roll_span;
   logic [F+2:0]         roll_diff;
   logic signed [7:0]    roll_slope;
   logic signed [PW-1:0] roll_prod;
   logic                 mute1_ff, upper1_ff;
   logic signed [XW-1:0] xup1_ff;
   logic signed [PW-1:0] prod1_ff;

   logic signed [XW-1:0] prod_ext, x_roll, x_raw, x_clamp, x_round;
   logic                 mute2_ff;
   logic [10:0]          q2_ff;

   logic [26:0]          recip_prod;
   logic [8:0]           code_sum;
   logic [7:0]           code_next;
   logic [7:0]           code_ff;

   // Configuration registers
   always_comb begin
      max_volume_in  = max_volume_ff;
      pin_present_in = pin_present_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_MAX_VOLUME: begin
               max_volume_in = csr_wdata;
            end
            CSR_PIN_PRESENT: begin
               pin_present_in = csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // Stored volume, positive requests clamp to 0 dB
   always_comb begin
      volume_level_in = volume_level_ff;
      if (cmd.vol_store) begin
         volume_level_in = req_volume_db[16] ? req_volume_db : 17'sd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_volume_ff   <= '0;
         pin_present_ff  <= 1'b0;
         volume_level_ff <= VOL_RESET;
         vld_ff          <= '0;
      end else begin
         max_volume_ff   <= max_volume_in;
         pin_present_ff  <= pin_present_in;
         volume_level_ff <= volume_level_in;
         vld_ff          <= {vld_ff[2:0], cmd.vol_start};
      end
   end

   // Stage 1: region compare, upper slope and roll-off product
   always_comb begin
      vol_ext    = {{(XW-17){volume_level_ff[16]}}, volume_level_ff};
      max_ext    = {{(XW-7){max_volume_ff[6]}}, max_volume_ff};
      slope_term = -(max_ext <<< (F + 1)) - (vol_ext <<< 2);
      x_upper    = (slope_term <<< 2) + slope_term;
      roll_span  = vol_ext + ROLL_OFFSET;
      roll_diff  = roll_span[F+2:0];
      roll_slope = {max_volume_ff[6], max_volume_ff} + 8'sd53;
      roll_prod  = $signed({1'b0, roll_diff}) * roll_slope;
   end

   always_ff @(posedge clock) begin
      mute1_ff  <= (vol_ext <= MUTE_LIMIT);
      upper1_ff <= (vol_ext >= UPPER_LIMIT);
      xup1_ff   <= x_upper;
      prod1_ff  <= roll_prod;
   end

   // Stage 2: select region, clamp, round and drop the fraction
   always_comb begin
      prod_ext = {{(XW-PW){prod1_ff[PW-1]}}, prod1_ff};
      x_roll   = X_TOP - (prod_ext <<< 1);
      x_raw    = upper1_ff ? xup1_ff : x_roll;
      priority if (x_raw < 0) begin
         x_clamp = '0;
      end else if (x_raw > X_TOP) begin
         x_clamp = X_TOP;
      end else begin
         x_clamp = x_raw;
      end
      x_round = x_clamp + X_HALF;
   end

   always_ff @(posedge clock) begin
      mute2_ff <= mute1_ff;
      q2_ff    <= x_round[F+10:F];
   end

   // Stage 3: divide by five through the reciprocal, offset and cap, or force the mute code
   always_comb begin
      recip_prod = 27'(q2_ff) * 27'(RECIP_FIVE);
      code_sum   = CODE_BASE + recip_prod[26:RECIP_SHIFT];
      priority if (mute2_ff) begin
         code_next = CODE_MUTE;
      end else if (code_sum > CODE_CAP) begin
         code_next = CODE_CAP[7:0];
      end else begin
         code_next = code_sum[7:0];
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_next;
   end

   // Result register, loaded when the controller issues an item
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_target          <= (cmd.entry.kind == KIND_PIN);
         rsp_reg_addr        <= cmd.entry.addr;
         rsp_reg_value       <= (cmd.entry.kind == KIND_VOL) ? code_ff : cmd.entry.value;
         rsp_delay_before_ms <= cmd.entry.delay;
         rsp_last            <= cmd.last;
      end
   end

   assign status.vol_done    = vld_ff[3];
   assign status.pin_present = pin_present_ff;

endmodule

FILE: src/dvps_ctrl.sv
module dvps_ctrl import dvps_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [2:0]    req_command,
   input  logic [1:0]    req_power_mode,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CALC = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type  state_ff, state_in;
   seq_type    seq_ff, seq_in, seq_sel;
   logic [3:0] step_ff, step_in;
   logic       initialized_ff, initialized_in;
   logic [1:0] power_ff, power_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept, has_seq, skip_item, last_item, slot_free;
   entry_type  entry, next_entry;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   // Current and following script entries
   always_comb begin
      entry      = script_entry(seq_ff, step_ff);
      next_entry = script_entry(seq_ff, step_ff + 4'd1);
      skip_item  = (entry.kind == KIND_PIN) && !status.pin_present;
      last_item  = entry.stop || ((next_entry.kind == KIND_PIN) && next_entry.stop &&
                                  !status.pin_present);
      slot_free  = !rsp_valid_ff || rsp_tready;
   end

   // Decode an accepted command into a sequence and the new state
   always_comb begin
      has_seq        = 1'b0;
      seq_sel        = SEQ_STREAM;
      initialized_in = initialized_ff;
      power_in       = power_ff;
      if (accept) begin
         unique case (req_command)
            CMD_INIT: begin
               if (!initialized_ff) begin
                  has_seq        = 1'b1;
                  seq_sel        = SEQ_INIT;
                  initialized_in = 1'b1;
                  power_in       = PWR_STANDBY;
               end
            end
            CMD_DEINIT: begin
               has_seq        = initialized_ff;
               seq_sel        = SEQ_SHUTDOWN;
               initialized_in = 1'b0;
               power_in       = PWR_OFF;
            end
            CMD_SET_VOLUME: begin
               has_seq = initialized_ff;
               seq_sel = SEQ_VOLUME;
            end
            CMD_SET_POWER: begin
               if (initialized_ff) begin
                  has_seq = 1'b1;
                  priority if (req_power_mode == PWR_ON) begin
                     seq_sel  = SEQ_PWR_ON;
                     power_in = PWR_ON;
                  end else if (req_power_mode == PWR_STANDBY) begin
                     seq_sel  = SEQ_MUTE;
                     power_in = PWR_STANDBY;
                  end else begin
                     seq_sel  = SEQ_SHUTDOWN;
                     power_in = PWR_OFF;
                  end
               end
            end
            CMD_STREAM_STARTED: begin
               has_seq = initialized_ff && (power_ff != PWR_OFF);
               seq_sel = SEQ_STREAM;
            end
            CMD_BUS_ERROR: begin
               has_seq  = 1'b1;
               seq_sel  = SEQ_MUTE;
               power_in = PWR_OFF;
            end
            default: begin
               has_seq = 1'b0;
            end
         endcase
      end
   end

   // Sequencer: wait for the volume code, then step the script
   always_comb begin
      state_in      = state_ff;
      seq_in        = seq_ff;
      step_in       = step_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      cmd           = '0;
      cmd.entry     = entry;
      cmd.last      = last_item;
      cmd.vol_store = accept && (req_command == CMD_SET_VOLUME);
      unique case (state_ff)
         ST_IDLE: begin
            if (has_seq) begin
               state_in      = ST_CALC;
               seq_in        = seq_sel;
               step_in       = '0;
               cmd.vol_start = 1'b1;
            end
         end
         ST_CALC: begin
            if (status.vol_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            priority if (skip_item) begin
               step_in = step_ff + 4'd1;
               if (entry.stop) begin
                  state_in = ST_IDLE;
               end
            end else if (slot_free) begin
               cmd.load     = 1'b1;
               rsp_valid_in = 1'b1;
               if (last_item) begin
                  state_in = ST_IDLE;
               end else begin
                  step_in = step_ff + 4'd1;
               end
            end else begin
               // hold the step while the output register is still occupied
               step_in = step_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         seq_ff         <= SEQ_STREAM;
         step_ff        <= '0;
         initialized_ff <= 1'b0;
         power_ff       <= PWR_OFF;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         seq_ff         <= seq_in;
         step_ff        <= step_in;
         initialized_ff <= initialized_in;
         power_ff       <= power_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   a_load_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result loaded over an untaken transfer");

   a_on_needs_init: assert property (@(posedge clock) disable iff (reset)
      !initialized_ff |-> (power_ff != PWR_ON))
      else $error("power on while not initialised");

   a_power_legal: assert property (@(posedge clock) disable iff (reset)
      (power_ff == PWR_OFF) || (power_ff == PWR_STANDBY) || (power_ff == PWR_ON))
      else $error("illegal power state");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= STEP_MAX)
      else $error("script step out of range");

   a_accept_no_emit: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_EMIT))
      else $error("emitting before the volume code is ready");

endmodule

FILE: src/dac_volume_power_sequencer.sv
// Command sequencer for a stereo audio DAC. Each command on req_ (kind on req_tuser)
// produces an ordered run of register writes and enable-pin levels on rsp_, the final
// one flagged by rsp_tlast; commands that change nothing produce no transfer. A command
// with results is accepted, passes through the volume-code pipeline (roll-off multiply,
// clamp and round, divide by five, output), then takes one script step per cycle while
// rsp_tready is high, a step being a result or a skipped pin entry when no enable pin is
// configured. Init is the longest at 14 steps. The next command is taken once the last
// result of the current one sits in the output register. Configuration writes are always
// ready and must only be issued while the block is idle.
module dac_volume_power_sequencer import dvps_pkg::*; #(
   parameter int VOLUME_FRAC_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // volume_db [16:0], power_mode [18:17], zero [23:19]
   input  logic [2:0]  req_tuser,   // command [2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // reg_addr [6:0], reg_value [14:7],
                                    // delay_before_ms [19:15], zero [23:20]
   output logic [0:0]  rsp_tuser,   // target [0]
   output logic        rsp_tlast
);

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          rsp_target;
   logic [6:0]    rsp_reg_addr;
   logic [7:0]    rsp_reg_value;
   logic [4:0]    rsp_delay_before_ms;

   assign csr_ready = 1'b1;

   dvps_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_command    (req_tuser),
      .req_power_mode (req_tdata[18:17]),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .status         (status),
      .cmd            (cmd)
   );

   dvps_datapath #(
      .VOLUME_FRAC_BITS (VOLUME_FRAC_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_write           (csr_valid && csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_volume_db       (req_tdata[16:0]),
      .cmd                 (cmd),
      .status              (status),
      .rsp_target          (rsp_target),
      .rsp_reg_addr        (rsp_reg_addr),
      .rsp_reg_value       (rsp_reg_value),
      .rsp_delay_before_ms (rsp_delay_before_ms),
      .rsp_last            (rsp_tlast)
   );

   // Pack the result fields
   assign rsp_tdata = {4'b0000, rsp_delay_before_ms, rsp_reg_value, rsp_reg_addr};
   assign rsp_tuser = rsp_target;

endmodule

FILE: tb/dvps_checker.sv
module dvps_checker import dvps_pkg::*; #(
   parameter int VOLUME_FRAC_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [6:0]  csr_wdata,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [23:0] req_tdata,   // volume_db [16:0], power_mode [18:17], zero [23:19]
   input  logic [2:0]  req_tuser,   // command [2:0]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [23:0] rsp_tdata,   // reg_addr [6:0], reg_value [14:7],
                                    // delay_before_ms [19:15], zero [23:20]
   input  logic [0:0]  rsp_tuser,   // target [0]
   input  logic        rsp_tlast,
   output int          pending,
   output int          error_count
);

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic TARGET_REG = 1'b0;
   localparam logic TARGET_PIN = 1'b1;

   typedef struct packed {
      logic       target;
      logic [6:0] addr;
      logic [7:0] value;
      logic [4:0] delay;
      logic       last;
   } dac_write_type;

   // Writes still owed by the block, oldest first, and the run of the current command
   dac_write_type writes_due[$];
   dac_write_type cmd_writes[$];

   // Shadow of the configuration and of the controller state
   logic signed [6:0]  max_volume;
   logic               pin_present;
   logic signed [16:0] volume_level;
   logic [1:0]         power_state;
   logic               initialized;

   // Map the stored level to the DAC attenuation code, in units of 1/(5*scale) of -2 dB
   function automatic logic [7:0] volume_code();
      longint scale, lvl, ceil_db, div, span, x, code;
      scale   = longint'(1) << VOLUME_FRAC_BITS;
      lvl     = volume_level;
      ceil_db = max_volume;
      div     = 5 * scale;
      span    = 206 * div;
      if (lvl <= -30 * scale) return CODE_MUTE;
      if (lvl >= -25 * scale)
         x = 5 * (-2 * ceil_db * scale - 4 * lvl);
      else
         x = span - 2 * (lvl + 30 * scale) * (ceil_db + 53);
      if (x < 0) x = 0;
      if (x > span) x = span;
      code = (x + div / 2) / div + longint'(CODE_BASE);
      if (code > longint'(CODE_CAP)) code = longint'(CODE_CAP);
      return code[7:0];
   endfunction

   function automatic void add_write(logic target, logic [6:0] addr, logic [7:0] value,
                                     logic [4:0] delay);
      dac_write_type w;
      w = '{target, addr, value, delay, 1'b0};
      cmd_writes.push_back(w);
   endfunction

   function automatic void add_pin(logic [7:0] level);
      if (pin_present) add_write(TARGET_PIN, PIN_ADDR, level, DELAY_NONE);
   endfunction

   function automatic void add_volume(logic [4:0] delay);
      logic [7:0] code;
      code = volume_code();
      add_write(TARGET_REG, REG_VOL_L, code, delay);
      add_write(TARGET_REG, REG_VOL_R, code, DELAY_NONE);
   endfunction

   function automatic void add_error_mute();
      add_pin(VAL_PIN_LOW);
      add_write(TARGET_REG, REG_MUTE, VAL_MUTE_BOTH, DELAY_NONE);
      power_state = PWR_OFF;
   endfunction

   // Work out the writes one command causes and advance the shadow state
   function automatic void predict_command(logic [2:0] cmd, logic [16:0] vol_raw,
                                           logic [1:0] mode);
      logic signed [16:0] vol;
      vol = vol_raw;
      if (vol > 0) vol = '0;
      cmd_writes.delete();
      case (cmd)
         CMD_INIT: begin
            if (!initialized) begin
               add_pin(VAL_PIN_LOW);
               add_write(TARGET_REG, REG_PAGE,     VAL_ZERO,      DELAY_NONE);
               add_write(TARGET_REG, REG_MUTE,     VAL_MUTE_BOTH, DELAY_NONE);
               add_write(TARGET_REG, REG_POWER,    VAL_STANDBY,   DELAY_NONE);
               add_write(TARGET_REG, REG_RESET,    VAL_RESET_ALL, DELAY_NONE);
               add_write(TARGET_REG, REG_PAGE,     VAL_ZERO,      DELAY_SETTLE);
               add_write(TARGET_REG, REG_MUTE,     VAL_MUTE_BOTH, DELAY_NONE);
               add_write(TARGET_REG, REG_POWER,    VAL_STANDBY,   DELAY_NONE);
               add_write(TARGET_REG, REG_PLL_REF,  VAL_PLL_REF,   DELAY_NONE);
               add_write(TARGET_REG, REG_CLK_MASK, VAL_CLK_MASK,  DELAY_NONE);
               add_write(TARGET_REG, REG_ROUTING,  VAL_ROUTING,   DELAY_NONE);
               add_volume(DELAY_NONE);
               add_write(TARGET_REG, REG_POWER,    VAL_ZERO,      DELAY_NONE);
               initialized = 1'b1;
               power_state = PWR_STANDBY;
            end
         end
         CMD_DEINIT: begin
            if (initialized) begin
               add_error_mute();
               add_write(TARGET_REG, REG_POWER, VAL_STANDBY, DELAY_NONE);
            end
            initialized = 1'b0;
            power_state = PWR_OFF;
         end
         CMD_SET_VOLUME: begin
            volume_level = vol;
            if (initialized) add_volume(DELAY_NONE);
         end
         CMD_SET_POWER: begin
            if (initialized) begin
               if (mode == PWR_ON) begin
                  add_write(TARGET_REG, REG_POWER, VAL_ZERO, DELAY_NONE);
                  add_volume(DELAY_SETTLE);
                  add_write(TARGET_REG, REG_MUTE, VAL_ZERO, DELAY_NONE);
                  add_pin(VAL_PIN_HIGH);
                  power_state = PWR_ON;
               end else if (mode == PWR_STANDBY) begin
                  add_pin(VAL_PIN_LOW);
                  add_write(TARGET_REG, REG_MUTE, VAL_MUTE_BOTH, DELAY_NONE);
                  power_state = PWR_STANDBY;
               end else begin
                  // off, and the spare mode code that reads as off
                  add_pin(VAL_PIN_LOW);
                  add_write(TARGET_REG, REG_MUTE, VAL_MUTE_BOTH, DELAY_NONE);
                  add_write(TARGET_REG, REG_POWER, VAL_STANDBY, DELAY_NONE);
                  power_state = PWR_OFF;
               end
            end
         end
         CMD_STREAM_STARTED: begin
            if (initialized && power_state != PWR_OFF)
               add_write(TARGET_REG, REG_POWER, VAL_ZERO, DELAY_NONE);
         end
         CMD_BUS_ERROR: add_error_mute();
         default: ;
      endcase
      if (cmd_writes.size() > 0) cmd_writes[cmd_writes.size() - 1].last = 1'b1;
      foreach (cmd_writes[i]) writes_due.push_back(cmd_writes[i]);
   endfunction

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         error_count++;
      end
   endfunction

   // Sample every channel at the rising edge: results first, then settings, then commands
   always @(posedge clock) begin : monitor
      dac_write_type got, want;
      if (reset) begin
         max_volume   = '0;
         pin_present  = 1'b0;
         volume_level = 17'(-15 * (1 << VOLUME_FRAC_BITS));
         power_state  = PWR_OFF;
         initialized  = 1'b0;
         error_count  = 0;
         writes_due.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tuser[0], rsp_tdata[6:0], rsp_tdata[14:7], rsp_tdata[19:15],
                    rsp_tlast};
            if (writes_due.size() == 0) begin
               $error("result transfer with nothing outstanding: addr 0x%0h value 0x%0h",
                      got.addr, got.value);
               error_count++;
            end else begin
               want = writes_due.pop_front();
               check_field("target", 8'(want.target), 8'(got.target));
               check_field("reg_addr", 8'(want.addr), 8'(got.addr));
               check_field("reg_value", want.value, got.value);
               check_field("delay_before_ms", 8'(want.delay), 8'(got.delay));
               check_field("last", 8'(want.last), 8'(got.last));
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_MAX_VOLUME) max_volume = csr_wdata;
            else if (csr_index == CSR_PIN_PRESENT) pin_present = csr_wdata[0];
         end
         if (req_tvalid && req_tready)
            predict_command(req_tuser, req_tdata[16:0], req_tdata[18:17]);
      end
      pending = writes_due.size();
   end

endmodule

FILE: tb/tb.sv
module tb import dvps_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC_BITS  = 8;
   localparam int DB_SCALE   = 1 << FRAC_BITS;
   localparam int MUTE_EDGE  = -30 * DB_SCALE;
   localparam int ROLL_EDGE  = -25 * DB_SCALE;
   localparam int FLOOR_VOL  = -144 * DB_SCALE;
   localparam int DRAIN_WAIT = 40;
   localparam int HOLD_LEN   = 400;
   localparam int PHASE_LEN  = 80;

   localparam logic [2:0] CMD_SPARE_LO    = 3'd6;
   localparam logic [2:0] CMD_SPARE_HI    = 3'd7;
   localparam logic [1:0] PWR_SPARE       = 2'd3;

   typedef enum int {READY_ALWAYS, READY_HALF, READY_MOSTLY, READY_RARELY} ready_mode_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [6:0]  csr_wdata = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;   // volume_db [16:0], power_mode [18:17], zero [23:19]
   logic [2:0]  req_tuser = '0;   // command [2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;        // reg_addr [6:0], reg_value [14:7],
                                  // delay_before_ms [19:15], zero [23:20]
   logic [0:0]  rsp_tuser;        // target [0]
   logic        rsp_tlast;

   int pending;
   int fail_count;
   int hold_requests = 0;
   int holds_done = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   dac_volume_power_sequencer #(.VOLUME_FRAC_BITS(FRAC_BITS)) i_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   dvps_checker #(.VOLUME_FRAC_BITS(FRAC_BITS)) i_checker (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .pending     (pending),
      .error_count (fail_count)
   );

   task automatic write_csr(logic [1:0] index, logic [6:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Offer one command and hold it until the transfer
   task automatic send_command(logic [2:0] cmd, logic [16:0] vol, logic [1:0] mode);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {5'b0, mode, vol};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic sender_gap(int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   // Drop valid, let every owed write arrive, then let the block go idle
   task automatic drain();
      sender_gap(1);
      wait (pending == 0);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   function automatic logic [16:0] random_volume();
      case ($urandom_range(0, 7))
         0:       return 17'(-int'($urandom_range(-ROLL_EDGE, -FLOOR_VOL)));
         1:       return 17'(-int'($urandom_range(-ROLL_EDGE, -MUTE_EDGE)));
         2, 3, 4: return 17'(-int'($urandom_range(0, -ROLL_EDGE)));
         5:       return 17'($urandom_range(1, 32767));
         6:       return 17'($urandom);
         default: begin
            case ($urandom_range(0, 3))
               0:       return 17'(MUTE_EDGE);
               1:       return 17'(MUTE_EDGE + 1);
               2:       return 17'(ROLL_EDGE - 1);
               default: return 17'(ROLL_EDGE);
            endcase
         end
      endcase
   endfunction

   // Weighted towards a live, initialised controller; the tail is plain noise
   task automatic send_random(output bit counted);
      logic [2:0] cmd;
      logic [1:0] mode;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 8) cmd = CMD_INIT;
      else if (pick < 13) cmd = CMD_DEINIT;
      else if (pick < 48) cmd = CMD_SET_VOLUME;
      else if (pick < 68) cmd = CMD_SET_POWER;
      else if (pick < 80) cmd = CMD_STREAM_STARTED;
      else if (pick < 88) cmd = CMD_BUS_ERROR;
      else cmd = 3'($urandom_range(0, 7));
      mode = ($urandom_range(0, 1) == 0) ? PWR_ON : 2'($urandom_range(0, 3));
      send_command(cmd, random_volume(), mode);
      counted = (cmd <= CMD_BUS_ERROR);
   endtask

   // Receiver: stretches of differing readiness, plus a long hold on request
   initial begin : receiver
      ready_mode_type mode;
      int seg_left;
      mode = READY_ALWAYS;
      seg_left = 0;
      forever begin
         @(negedge clock);
         if (hold_requests != holds_done) begin
            holds_done++;
            rsp_tready <= 1'b0;
            repeat (HOLD_LEN) @(negedge clock);
         end else begin
            if (seg_left == 0) begin
               mode = ready_mode_type'($urandom_range(0, 3));
               seg_left = $urandom_range(10, 200);
            end
            seg_left--;
            case (mode)
               READY_ALWAYS: rsp_tready <= 1'b1;
               READY_HALF:   rsp_tready <= 1'($urandom_range(0, 1));
               READY_MOSTLY: rsp_tready <= ($urandom_range(0, 7) != 0);
               default:      rsp_tready <= ($urandom_range(0, 7) == 0);
            endcase
         end
      end
   end

   initial begin : stimulus
      int sent;
      int burst_left;
      int max_db;
      bit pin_on;
      bit counted;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      write_csr(CSR_MAX_VOLUME, 7'(0));
      write_csr(CSR_PIN_PRESENT, 7'(1));

      // Directed: uninitialised corners, both curve edges, each power mode
      send_command(CMD_STREAM_STARTED, 17'(0), PWR_OFF);
      send_command(CMD_SET_POWER, 17'(0), PWR_ON);
      send_command(CMD_DEINIT, 17'(0), PWR_OFF);
      send_command(CMD_SET_VOLUME, 17'(0), PWR_OFF);
      send_command(CMD_INIT, 17'(0), PWR_OFF);
      send_command(CMD_INIT, 17'(0), PWR_OFF);
      send_command(CMD_SET_VOLUME, 17'(MUTE_EDGE), PWR_OFF);
      send_command(CMD_SET_VOLUME, 17'(MUTE_EDGE + 1), PWR_OFF);
      send_command(CMD_SET_VOLUME, 17'(ROLL_EDGE - 1), PWR_OFF);
      send_command(CMD_SET_VOLUME, 17'(ROLL_EDGE), PWR_OFF);
      send_command(CMD_SET_VOLUME, 17'(32767), PWR_SPARE);
      send_command(CMD_SET_VOLUME, 17'(-65536), PWR_OFF);
      send_command(CMD_SET_POWER, 17'(0), PWR_ON);
      send_command(CMD_STREAM_STARTED, 17'(0), PWR_OFF);
      send_command(CMD_SET_POWER, 17'(0), PWR_STANDBY);
      send_command(CMD_STREAM_STARTED, 17'(0), PWR_OFF);
      send_command(CMD_SET_POWER, 17'(0), PWR_SPARE);
      send_command(CMD_STREAM_STARTED, 17'(0), PWR_OFF);
      send_command(CMD_BUS_ERROR, 17'(0), PWR_OFF);
      send_command(CMD_SET_VOLUME, 17'(-15 * DB_SCALE), PWR_OFF);
      send_command(CMD_DEINIT, 17'(0), PWR_OFF);
      send_command(CMD_BUS_ERROR, 17'(0), PWR_OFF);
      send_command(CMD_SPARE_LO, 17'(0), PWR_OFF);
      send_command(CMD_SPARE_HI, 17'(0), PWR_OFF);
      send_command(CMD_INIT, 17'(0), PWR_OFF);
      send_command(CMD_SET_POWER, 17'(0), PWR_OFF);
      drain();

      // Random phases, each under its own setting, extremes first
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0:       begin max_db = 24;  pin_on = 1'b0; end
            1:       begin max_db = -60; pin_on = 1'b1; end
            2:       begin max_db = 63;  pin_on = 1'b0; end
            3:       begin max_db = -64; pin_on = 1'b1; end
            default: begin
               max_db = int'($urandom_range(0, 84)) - 60;
               pin_on = 1'($urandom_range(0, 1));
            end
         endcase
         write_csr(CSR_MAX_VOLUME, 7'(max_db));
         write_csr(CSR_PIN_PRESENT, 7'(pin_on));
         sent = 0;
         burst_left = 0;
         while (sent < PHASE_LEN) begin
            if (burst_left == 0) begin
               sender_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10));
               burst_left = $urandom_range(1, 16);
            end
            burst_left--;
            // hold the receiver off while commands keep coming
            if (phase == 0 && sent == 30) hold_requests++;
            // now and then stop and let every owed write arrive
            if ((phase == 1 && sent == 40) || $urandom_range(0, 49) == 0) begin
               sender_gap(1);
               wait (pending == 0);
            end
            send_random(counted);
            if (counted) sent++;
         end
         drain();
      end

      if (fail_count == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

   initial begin : watchdog
      #2_000_000;
      $display("tb: FAIL");
      $finish;
   end

endmodule
